### rtl/surface_pressure_force_accumulate_top_assert.svh
// assertion macros used by the checker
`ifndef SURFACE_PRESSURE_FORCE_ACCUMULATE_TOP_ASSERT_SVH
`define SURFACE_PRESSURE_FORCE_ACCUMULATE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

### rtl/spfa_pkg.sv
package spfa_pkg;

    localparam int COORD_W    = 32;
    localparam int EDGE_W     = (COORD_W < 32) ? COORD_W : 32;
    localparam int FRAC_W     = 16;
    localparam int FS_W       = 18;
    localparam int ACC_W      = 64;
    localparam int HALF_W     = ACC_W / 2;
    localparam int PROD_W     = 2 * ACC_W;
    localparam int PSUM_W     = COORD_W + 2;
    localparam int MID_W      = COORD_W + 3;
    localparam int CP_W       = COORD_W + 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CNT_W      = 3;
    localparam int MUL_LAST   = 4;
    localparam int QUARTER    = 1 << (FRAC_W - 2);

    // divide by three as multiply by (2^s + 1) / 3 and shift by s, exact for |n| < 2^s
    localparam int DIV3_SHIFT = COORD_W + 1;
    localparam logic [ACC_W-1:0] DIV3_MUL =
        ((64'd1 << DIV3_SHIFT) + 64'd1) / 64'd3;

    localparam logic signed [CP_W-1:0] CP_OFFSET = CP_W'(2 << FRAC_W);
    localparam logic signed [FS_W-1:0] FS_U_RESET = FS_W'(1 << FRAC_W);
    localparam logic signed [FS_W-1:0] FS_V_RESET = '0;

    localparam logic [CFG_IDX_W-1:0] REG_FREE_STREAM_U = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FREE_STREAM_V = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] vert0_x;
        logic signed [COORD_W-1:0] vert0_y;
        logic signed [COORD_W-1:0] vert0_z;
        logic signed [COORD_W-1:0] vert1_x;
        logic signed [COORD_W-1:0] vert1_y;
        logic signed [COORD_W-1:0] vert1_z;
        logic signed [COORD_W-1:0] vert2_x;
        logic signed [COORD_W-1:0] vert2_y;
        logic signed [COORD_W-1:0] vert2_z;
        logic signed [COORD_W-1:0] press0;
        logic signed [COORD_W-1:0] press1;
        logic signed [COORD_W-1:0] press2;
    } face_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] lift_sum;
        logic signed [ACC_W-1:0] drag_sum;
        logic signed [ACC_W-1:0] moment_sum;
    } sums_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_FIN,
        ST_POST,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_AY_BZ,
        OP_AZ_BY,
        OP_AX_BZ,
        OP_AZ_BX,
        OP_MEAN,
        OP_DCX,
        OP_DCY,
        OP_LIFT_V,
        OP_LIFT_U,
        OP_DRAG_U,
        OP_DRAG_V,
        OP_MOM_X,
        OP_MOM_Y
    } op_t;

    typedef enum logic [1:0] {
        MODE_RAW,
        MODE_DIV,
        MODE_SCALE
    } mode_t;

endpackage

### rtl/surface_pressure_force_accumulate_top.sv
// Surface pressure force accumulator. Each transfer in carries one triangle (three Q16.16
// vertices and three vertex pressures); each transfer out carries the running lift, drag
// and moment sums in Q32.32, saturating. A face takes 13 products through one 32x32
// multiplier, four partial products each, and a new face is taken only once the last
// one is through; a result that has not been taken holds the next one back. A write to
// free_stream_u or free_stream_v clears the sums; writes to any other index are ignored.
module surface_pressure_force_accumulate_top
    import spfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  face_t                 in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sums_t                 out_data,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [FS_W-1:0]       cfg_data
);

    function automatic logic signed [EDGE_W-1:0] edge_sat(
        input logic signed [COORD_W-1:0] hi,
        input logic signed [COORD_W-1:0] lo
    );
        logic signed [COORD_W:0]         d;
        logic [COORD_W-EDGE_W+1:0]       top_bits;
        d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
        top_bits = d[COORD_W:EDGE_W-1];
        if (top_bits == '0 || top_bits == '1)
            return d[EDGE_W-1:0];
        else if (d[COORD_W])
            return {1'b1, {(EDGE_W-1){1'b0}}};
        else
            return {1'b0, {(EDGE_W-1){1'b1}}};
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    sums_t out_reg, out_next;

    logic signed [FS_W-1:0] fs_u_reg, fs_u_next;
    logic signed [FS_W-1:0] fs_v_reg, fs_v_next;
    logic signed [ACC_W-1:0] lift_reg, lift_next;
    logic signed [ACC_W-1:0] drag_reg, drag_next;
    logic signed [ACC_W-1:0] moment_reg, moment_next;

    logic signed [EDGE_W-1:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [EDGE_W-1:0] bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic signed [PSUM_W-1:0] psum_reg, psum_next;
    logic signed [MID_W-1:0]  xmid_reg, xmid_next, ymid_reg, ymid_next;
    logic signed [CP_W-1:0]   cp_reg, cp_next;
    logic signed [ACC_W-1:0]  t_reg, t_next;
    logic signed [ACC_W-1:0]  xnorm_reg, xnorm_next, ynorm_reg, ynorm_next;
    logic signed [ACC_W-1:0]  dcx_reg, dcx_next, dcy_reg, dcy_next;

    logic [ACC_W-1:0]  a_mag_reg, a_mag_next, b_mag_reg, b_mag_next;
    logic              neg_reg, neg_next;
    logic [ACC_W-1:0]  pp_reg, pp_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] res_reg, res_next;

    // operand select and shared multiplier signals
    mode_t                   mode;
    logic signed [ACC_W-1:0] op_a, op_b;
    logic [HALF_W-1:0]       a_half, b_half;
    logic [ACC_W-1:0]        pp_full;
    logic [1:0]              pp_idx;
    logic [PROD_W-1:0]       pp_shifted;
    logic [PROD_W-1:0]       fin_in;
    logic signed [PROD_W-1:0] fin_s, scaled;
    logic                    scale_ovf;
    logic signed [ACC_W:0]   nd_diff;
    logic signed [ACC_W-1:0] acc_sel;
    logic                    acc_sub;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic                    out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOAD;
            end
            ST_LOAD: state_next = ST_MUL;
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_LAST))
                    state_next = ST_FIN;
            end
            ST_FIN:  state_next = ST_POST;
            ST_POST:
            begin
                if (op_reg == OP_MOM_Y)
                    state_next = ST_DONE;
                else
                    state_next = ST_LOAD;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // operand routing per step
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        mode = MODE_RAW;
        case (op_reg)
            OP_AY_BZ:  begin op_a = ACC_W'(ay_reg);   op_b = ACC_W'(bz_reg); end
            OP_AZ_BY:  begin op_a = ACC_W'(az_reg);   op_b = ACC_W'(by_reg); end
            OP_AX_BZ:  begin op_a = ACC_W'(ax_reg);   op_b = ACC_W'(bz_reg); end
            OP_AZ_BX:  begin op_a = ACC_W'(az_reg);   op_b = ACC_W'(bx_reg); end
            OP_MEAN:
            begin
                op_a = ACC_W'(psum_reg);
                op_b = DIV3_MUL;
                mode = MODE_DIV;
            end
            OP_DCX:    begin op_a = ACC_W'(cp_reg);   op_b = xnorm_reg; mode = MODE_SCALE; end
            OP_DCY:    begin op_a = ACC_W'(cp_reg);   op_b = ynorm_reg; mode = MODE_SCALE; end
            OP_LIFT_V: begin op_a = dcx_reg; op_b = ACC_W'(fs_v_reg); mode = MODE_SCALE; end
            OP_LIFT_U: begin op_a = dcy_reg; op_b = ACC_W'(fs_u_reg); mode = MODE_SCALE; end
            OP_DRAG_U: begin op_a = dcx_reg; op_b = ACC_W'(fs_u_reg); mode = MODE_SCALE; end
            OP_DRAG_V: begin op_a = dcy_reg; op_b = ACC_W'(fs_v_reg); mode = MODE_SCALE; end
            OP_MOM_X:  begin op_a = ACC_W'(xmid_reg); op_b = dcy_reg; mode = MODE_SCALE; end
            OP_MOM_Y:  begin op_a = ACC_W'(ymid_reg); op_b = dcx_reg; mode = MODE_SCALE; end
            default:   begin op_a = '0; op_b = '0; mode = MODE_RAW; end
        endcase
    end

    // one 32x32 partial product per cycle, added in the cycle after
    assign a_half  = cnt_reg[0] ? a_mag_reg[ACC_W-1:HALF_W] : a_mag_reg[HALF_W-1:0];
    assign b_half  = cnt_reg[1] ? b_mag_reg[ACC_W-1:HALF_W] : b_mag_reg[HALF_W-1:0];
    assign pp_full = a_half * b_half;
    assign pp_idx  = 2'(cnt_reg - CNT_W'(1));

    always_comb
    begin
        case (pp_idx)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd1:    pp_shifted = PROD_W'(pp_reg) << HALF_W;
            2'd2:    pp_shifted = PROD_W'(pp_reg) << HALF_W;
            2'd3:    pp_shifted = PROD_W'(pp_reg) << ACC_W;
            default: pp_shifted = '0;
        endcase
    end

    // sign and scale the magnitude product: floor for scaled, toward zero for divide
    assign fin_in    = (mode == MODE_DIV) ? (prod_reg >> DIV3_SHIFT) : prod_reg;
    assign fin_s     = neg_reg ? $signed(~fin_in + PROD_W'(1)) : $signed(fin_in);
    assign scaled    = fin_s >>> FRAC_W;
    assign scale_ovf = (scaled[PROD_W-1:ACC_W-1] != '0) && (scaled[PROD_W-1:ACC_W-1] != '1);

    // halved cross difference, floor toward minus infinity
    assign nd_diff = (op_reg == OP_AZ_BY) ?
        ({res_reg[ACC_W-1], res_reg} - {t_reg[ACC_W-1], t_reg}) :
        ({t_reg[ACC_W-1], t_reg} - {res_reg[ACC_W-1], res_reg});

    // saturating accumulate
    always_comb
    begin
        acc_sel = lift_reg;
        acc_sub = 1'b0;
        case (op_reg)
            OP_LIFT_V: begin acc_sel = lift_reg;   acc_sub = 1'b1; end
            OP_LIFT_U: begin acc_sel = lift_reg;   acc_sub = 1'b0; end
            OP_DRAG_U: begin acc_sel = drag_reg;   acc_sub = 1'b0; end
            OP_DRAG_V: begin acc_sel = drag_reg;   acc_sub = 1'b0; end
            OP_MOM_X:  begin acc_sel = moment_reg; acc_sub = 1'b0; end
            OP_MOM_Y:  begin acc_sel = moment_reg; acc_sub = 1'b1; end
            default:   begin acc_sel = lift_reg;   acc_sub = 1'b0; end
        endcase
    end

    assign acc_sum = acc_sub ?
        ({acc_sel[ACC_W-1], acc_sel} - {res_reg[ACC_W-1], res_reg}) :
        ({acc_sel[ACC_W-1], acc_sel} + {res_reg[ACC_W-1], res_reg});
    assign acc_sat = (acc_sum[ACC_W] == acc_sum[ACC_W-1]) ? acc_sum[ACC_W-1:0] :
        (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}});

    // datapath next values
    always_comb
    begin
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        fs_u_next      = fs_u_reg;
        fs_v_next      = fs_v_reg;
        lift_next      = lift_reg;
        drag_next      = drag_reg;
        moment_next    = moment_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        bz_next        = bz_reg;
        psum_next      = psum_reg;
        xmid_next      = xmid_reg;
        ymid_next      = ymid_reg;
        cp_next        = cp_reg;
        t_next         = t_reg;
        xnorm_next     = xnorm_reg;
        ynorm_next     = ynorm_reg;
        dcx_next       = dcx_reg;
        dcy_next       = dcy_reg;
        a_mag_next     = a_mag_reg;
        b_mag_next     = b_mag_reg;
        neg_next       = neg_reg;
        pp_next        = pp_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = OP_AY_BZ;
                    ax_next   = edge_sat(in_data.vert1_x, in_data.vert0_x);
                    ay_next   = edge_sat(in_data.vert1_y, in_data.vert0_y);
                    az_next   = edge_sat(in_data.vert1_z, in_data.vert0_z);
                    bx_next   = edge_sat(in_data.vert2_x, in_data.vert0_x);
                    by_next   = edge_sat(in_data.vert2_y, in_data.vert0_y);
                    bz_next   = edge_sat(in_data.vert2_z, in_data.vert0_z);
                    psum_next = PSUM_W'(in_data.press0) + PSUM_W'(in_data.press1)
                              + PSUM_W'(in_data.press2);
                    xmid_next = MID_W'(in_data.vert0_x) + MID_W'(in_data.vert1_x)
                              + MID_W'(in_data.vert2_x) - MID_W'(QUARTER);
                    ymid_next = MID_W'(in_data.vert0_y) + MID_W'(in_data.vert1_y)
                              + MID_W'(in_data.vert2_y);
                end
            end
            ST_LOAD:
            begin
                a_mag_next = op_a[ACC_W-1] ? (~op_a + ACC_W'(1)) : op_a;
                b_mag_next = op_b[ACC_W-1] ? (~op_b + ACC_W'(1)) : op_b;
                neg_next   = op_a[ACC_W-1] ^ op_b[ACC_W-1];
                prod_next  = '0;
                cnt_next   = '0;
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg != CNT_W'(MUL_LAST))
                    pp_next = pp_full;
                if (cnt_reg != '0)
                    prod_next = prod_reg + pp_shifted;
            end
            ST_FIN:
            begin
                if (mode == MODE_SCALE)
                begin
                    if (scale_ovf)
                        res_next = scaled[PROD_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                    : {1'b0, {(ACC_W-1){1'b1}}};
                    else
                        res_next = scaled[ACC_W-1:0];
                end
                else
                    res_next = fin_s[ACC_W-1:0];
            end
            ST_POST:
            begin
                op_next = op_t'(op_reg + 4'd1);
                case (op_reg)
                    OP_AY_BZ:  t_next = res_reg;
                    OP_AZ_BY:  xnorm_next = nd_diff[ACC_W:1];
                    OP_AX_BZ:  t_next = res_reg;
                    OP_AZ_BX:  ynorm_next = nd_diff[ACC_W:1];
                    OP_MEAN:   cp_next = {res_reg[CP_W-2:0], 1'b0} - CP_OFFSET;
                    OP_DCX:    dcx_next = res_reg;
                    OP_DCY:    dcy_next = res_reg;
                    OP_LIFT_V: lift_next = acc_sat;
                    OP_LIFT_U: lift_next = acc_sat;
                    OP_DRAG_U: drag_next = acc_sat;
                    OP_DRAG_V: drag_next = acc_sat;
                    OP_MOM_X:  moment_next = acc_sat;
                    OP_MOM_Y:  moment_next = acc_sat;
                    default:   t_next = t_reg;
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.lift_sum   = lift_reg;
                    out_next.drag_sum   = drag_reg;
                    out_next.moment_sum = moment_reg;
                end
            end
            default: op_next = op_reg;
        endcase

        // a write to free_stream_u or free_stream_v clears the sums
        if (cfg_wen)
        begin
            if (cfg_index == REG_FREE_STREAM_U || cfg_index == REG_FREE_STREAM_V)
            begin
                lift_next   = '0;
                drag_next   = '0;
                moment_next = '0;
            end
            if (cfg_index == REG_FREE_STREAM_U)
                fs_u_next = cfg_data;
            if (cfg_index == REG_FREE_STREAM_V)
                fs_v_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_AY_BZ;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            fs_u_reg      <= FS_U_RESET;
            fs_v_reg      <= FS_V_RESET;
            lift_reg      <= '0;
            drag_reg      <= '0;
            moment_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            fs_u_reg      <= fs_u_next;
            fs_v_reg      <= fs_v_next;
            lift_reg      <= lift_next;
            drag_reg      <= drag_next;
            moment_reg    <= moment_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        bz_reg    <= bz_next;
        psum_reg  <= psum_next;
        xmid_reg  <= xmid_next;
        ymid_reg  <= ymid_next;
        cp_reg    <= cp_next;
        t_reg     <= t_next;
        xnorm_reg <= xnorm_next;
        ynorm_reg <= ynorm_next;
        dcx_reg   <= dcx_next;
        dcy_reg   <= dcy_next;
        a_mag_reg <= a_mag_next;
        b_mag_reg <= b_mag_next;
        neg_reg   <= neg_next;
        pp_reg    <= pp_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
    end

endmodule

### rtl/spfa_checker.sv
`include "surface_pressure_force_accumulate_top_assert.svh"

module spfa_checker
    import spfa_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input sums_t out_data
);

    // a waiting result holds still
    `SPFA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // one face at a time: the port closes right after a transfer in
    `SPFA_ASSERT_NXT(a_in_busy, in_valid && in_ready, !in_ready)

    // an idle port stays open
    `SPFA_ASSERT_NXT(a_in_idle, in_ready && !in_valid, in_ready)

    // a new result appears only as the block returns to idle
    `SPFA_ASSERT_IMP(a_out_rise, $rose(out_valid), $rose(in_ready))

endmodule

bind surface_pressure_force_accumulate_top spfa_checker u_spfa_checker (.*);
